>>> sv/torp_pkg.sv
package torp_pkg;

  // One byte word as it travels from the front end to the parser.
  typedef struct packed {
    logic       first;  // opens a transaction
    logic       last;   // closes a transaction
    logic [7:0] data;
  } torp_word_t;

  // Fill status of the byte queue.
  typedef struct packed {
    logic full;
    logic empty;
  } torp_qstat_t;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

>>> sv/torp_front.sv
module torp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  ready_o,
  output logic                  word_valid_o,
  output torp_pkg::torp_word_t  word_o,
  input  logic                  word_ready_i
);

  logic first_q, first_d;

  assign ready_o      = word_ready_i;
  assign word_valid_o = valid_i;

  always_comb begin
    word_o.first = first_q;
    word_o.last  = last_byte_i;
    word_o.data  = data_byte_i;
  end

  // Mark the word after a closing word as the opening word of the next transaction.
  always_comb begin
    first_d = first_q;
    if (valid_i && word_ready_i) begin
      first_d = last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else begin
      first_q <= first_d;
    end
  end

endmodule

>>> sv/torp_queue.sv
module torp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  torp_pkg::torp_word_t  push_word_i,
  input  logic                  pop_i,
  output torp_pkg::torp_word_t  pop_word_o,
  output torp_pkg::torp_qstat_t stat_o
);

  localparam int unsigned CNT_W = torp_pkg::QPTR_W + 1;

  torp_pkg::torp_word_t           mem_q [torp_pkg::QUEUE_DEPTH];
  logic [torp_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [torp_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]               count_q, count_d;

  assign stat_o.full  = (count_q == CNT_W'(torp_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign pop_word_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> sv/torp_back.sv
module torp_back #(
  parameter int unsigned ADDRESS_BYTES  = 20,
  parameter int unsigned ASSET_ID_BYTES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 word_valid_i,
  input  torp_pkg::torp_word_t word_i,
  output logic                 pop_o,
  input  logic [15:0]          output_count_i,
  input  logic                 check_locktime_i,
  input  logic [31:0]          expected_type_id_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [63:0]          amount_sum_o,
  output logic [31:0]          address_total_o
);

  localparam logic [2:0] PH_ASSET  = 3'd1;
  localparam logic [2:0] PH_TYPE   = 3'd2;
  localparam logic [2:0] PH_AMOUNT = 3'd3;
  localparam logic [2:0] PH_LOCK   = 3'd4;
  localparam logic [2:0] PH_THRESH = 3'd5;
  localparam logic [2:0] PH_NADDR  = 3'd6;
  localparam logic [2:0] PH_ADDR   = 3'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BUFEND    = 3'd1;
  localparam logic [2:0] ST_BADTYPE   = 3'd2;
  localparam logic [2:0] ST_LOCKED    = 3'd3;
  localparam logic [2:0] ST_BADTHRESH = 3'd4;

  localparam logic [6:0] ASSET_SZ = 7'(ASSET_ID_BYTES);
  localparam logic [6:0] ADDR_SZ  = 7'(ADDRESS_BYTES);

  logic [2:0]  phase_q, phase_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] shift_q, shift_d;
  logic [31:0] thresh_q, thresh_d;
  logic [31:0] addr_left_q, addr_left_d;
  logic [15:0] recs_q, recs_d;
  logic [63:0] sum_q, sum_d;
  logic [31:0] addr_cnt_q, addr_cnt_d;
  logic        reported_q, reported_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q;
  logic [63:0] amount_sum_q;
  logic [31:0] address_total_q;

  logic [2:0]  ph_c;
  logic [5:0]  cnt_c;
  logic [63:0] shift_c, shift_n;
  logic [15:0] rec_c;
  logic [6:0]  cnt_inc, fsize;
  logic [31:0] al_dec;
  logic        st_v;
  logic [2:0]  st;
  logic [63:0] res_sum;
  logic [31:0] res_total;

  assign pop_o           = word_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign amount_sum_o    = amount_sum_q;
  assign address_total_o = address_total_q;

  // Field context: a fresh record set on the opening word, the held one otherwise.
  always_comb begin
    if (word_i.first) begin
      ph_c    = PH_ASSET;
      cnt_c   = '0;
      shift_c = '0;
      rec_c   = output_count_i;
    end else begin
      ph_c    = phase_q;
      cnt_c   = cnt_q;
      shift_c = shift_q;
      rec_c   = recs_q;
    end
  end

  always_comb begin
    case (ph_c)
      PH_ASSET:  fsize = ASSET_SZ;
      PH_TYPE:   fsize = 7'd4;
      PH_AMOUNT: fsize = 7'd8;
      PH_LOCK:   fsize = 7'd8;
      PH_THRESH: fsize = 7'd4;
      PH_NADDR:  fsize = 7'd4;
      default:   fsize = ADDR_SZ;
    endcase
  end

  assign shift_n = {shift_c[55:0], word_i.data};
  assign cnt_inc = {1'b0, cnt_c} + 7'd1;
  assign al_dec  = addr_left_q - 32'd1;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    thresh_d    = thresh_q;
    addr_left_d = addr_left_q;
    recs_d      = recs_q;
    sum_d       = sum_q;
    addr_cnt_d  = addr_cnt_q;
    reported_d  = reported_q;
    st_v        = 1'b0;
    st          = ST_OK;
    res_sum     = sum_q;
    res_total   = addr_cnt_q;

    if (pop_o && !reported_q) begin
      phase_d = ph_c;
      cnt_d   = cnt_c;
      shift_d = shift_c;
      recs_d  = rec_c;
      if (word_i.first && (output_count_i == '0)) begin
        st_v = 1'b1;
        st   = ST_OK;
      end else if (cnt_inc < fsize) begin
        cnt_d   = cnt_inc[5:0];
        shift_d = shift_n;
      end else begin
        cnt_d   = '0;
        shift_d = '0;
        case (ph_c)
          PH_ASSET: begin
            phase_d = PH_TYPE;
          end
          PH_TYPE: begin
            if (shift_n[31:0] != expected_type_id_i) begin
              st_v = 1'b1;
              st   = ST_BADTYPE;
            end else begin
              phase_d = PH_AMOUNT;
            end
          end
          PH_AMOUNT: begin
            sum_d   = sum_q + shift_n;
            phase_d = PH_LOCK;
          end
          PH_LOCK: begin
            if (check_locktime_i && (shift_n != '0)) begin
              st_v = 1'b1;
              st   = ST_LOCKED;
            end else begin
              phase_d = PH_THRESH;
            end
          end
          PH_THRESH: begin
            thresh_d = shift_n[31:0];
            phase_d  = PH_NADDR;
          end
          PH_NADDR: begin
            addr_left_d = shift_n[31:0];
            if (thresh_q > shift_n[31:0]) begin
              st_v = 1'b1;
              st   = ST_BADTHRESH;
            end else if (shift_n[31:0] == '0) begin
              recs_d = rec_c - 16'd1;
              if (recs_d == '0) begin
                st_v = 1'b1;
                st   = ST_OK;
              end else begin
                phase_d = PH_ASSET;
              end
            end else begin
              phase_d = PH_ADDR;
            end
          end
          default: begin
            if (addr_cnt_q != '1) begin
              addr_cnt_d = addr_cnt_q + 32'd1;
            end
            addr_left_d = al_dec;
            if (al_dec == '0) begin
              recs_d = rec_c - 16'd1;
              if (recs_d == '0) begin
                st_v = 1'b1;
                st   = ST_OK;
              end else begin
                phase_d = PH_ASSET;
              end
            end
          end
        endcase
      end
      if (!st_v && word_i.last) begin
        st_v = 1'b1;
        st   = ST_BUFEND;
      end
      if (st_v) begin
        reported_d = 1'b1;
      end
    end

    // Take the totals for the status word before the closing word drops them.
    res_sum   = sum_d;
    res_total = addr_cnt_d;

    // Drop all transaction state on the closing word.
    if (pop_o && word_i.last) begin
      phase_d     = PH_ASSET;
      cnt_d       = '0;
      shift_d     = '0;
      thresh_d    = '0;
      addr_left_d = '0;
      recs_d      = '0;
      sum_d       = '0;
      addr_cnt_d  = '0;
      reported_d  = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (st_v) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_v) begin
      status_q        <= st;
      amount_sum_q    <= res_sum;
      address_total_q <= res_total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ASSET;
      cnt_q       <= '0;
      shift_q     <= '0;
      thresh_q    <= '0;
      addr_left_q <= '0;
      recs_q      <= '0;
      sum_q       <= '0;
      addr_cnt_q  <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      shift_q     <= shift_d;
      thresh_q    <= thresh_d;
      addr_left_q <= addr_left_d;
      recs_q      <= recs_d;
      sum_q       <= sum_d;
      addr_cnt_q  <= addr_cnt_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> sv/transfer_output_record_parser.sv
// Transfer output record parser. Feed a serialised transaction one byte word per cycle,
// with last_byte_i high on its final word; one status word comes out per transaction
// (ok, buffer end, bad type, locked, bad threshold) with the wrapping 64-bit amount sum
// and the saturating address count seen so far. Throughput is one byte per cycle while
// no status word waits to be taken, bound by the byte-at-a-time field shifter of the
// parser. The byte that decides a status word passes the four-word byte queue, then the
// parser's result register. Byte intake continues while a status word waits to be
// taken, until the queue fills. Write configuration only while the block is idle;
// output_count is sampled at each transaction's first byte.
module transfer_output_record_parser #(
  parameter int unsigned ADDRESS_BYTES  = 20,
  parameter int unsigned ASSET_ID_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // status words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] amount_sum_o,
  output logic [31:0] address_total_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [1:0] REG_OUTPUT_COUNT   = 2'd0;
  localparam logic [1:0] REG_CHECK_LOCKTIME = 2'd1;
  localparam logic [1:0] REG_EXPECTED_TYPE  = 2'd2;

  logic [15:0] output_count_q, output_count_d;
  logic        check_locktime_q, check_locktime_d;
  logic [31:0] expected_type_id_q, expected_type_id_d;

  logic                  front_valid;
  torp_pkg::torp_word_t  front_word;
  logic                  q_push;
  logic                  q_pop;
  torp_pkg::torp_word_t  q_word;
  torp_pkg::torp_qstat_t q_stat;

  // Configuration: always ready, ignore writes beyond the register list.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    output_count_d     = output_count_q;
    check_locktime_d   = check_locktime_q;
    expected_type_id_d = expected_type_id_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_OUTPUT_COUNT:   output_count_d     = cfg_data_i[15:0];
        REG_CHECK_LOCKTIME: check_locktime_d   = cfg_data_i[0];
        REG_EXPECTED_TYPE:  expected_type_id_d = cfg_data_i;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_count_q     <= '0;
      check_locktime_q   <= 1'b0;
      expected_type_id_q <= 32'd7;
    end else begin
      output_count_q     <= output_count_d;
      check_locktime_q   <= check_locktime_d;
      expected_type_id_q <= expected_type_id_d;
    end
  end

  // Front end: tag each word with its transaction boundaries.
  torp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .ready_o      (in_ready_o),
    .word_valid_o (front_valid),
    .word_o       (front_word),
    .word_ready_i (!q_stat.full)
  );

  assign q_push = front_valid && !q_stat.full;

  // Short queue decouples intake from the parser and its result register.
  torp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (front_word),
    .pop_i       (q_pop),
    .pop_word_o  (q_word),
    .stat_o      (q_stat)
  );

  // Back end: field parser, checks, sums and the result register.
  torp_back #(
    .ADDRESS_BYTES  (ADDRESS_BYTES),
    .ASSET_ID_BYTES (ASSET_ID_BYTES)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .word_valid_i       (!q_stat.empty),
    .word_i             (q_word),
    .pop_o              (q_pop),
    .output_count_i     (output_count_q),
    .check_locktime_i   (check_locktime_q),
    .expected_type_id_i (expected_type_id_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .amount_sum_o       (amount_sum_o),
    .address_total_o    (address_total_o)
  );

  // The queue can never read as both full and empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("byte queue full and empty at once");

  // The parser never draws a word from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.empty |-> !q_pop)
    else $error("pop from empty byte queue");

  // A new status word only follows a word taken by the parser.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_pop))
    else $error("status word without a parsed byte");

endmodule

>>> bench/transfer_output_record_parser_test.sv
module transfer_output_record_parser_test;

  localparam int unsigned ADDRESS_BYTES   = 20;
  localparam int unsigned ASSET_ID_BYTES  = 32;
  // Passage through queue and result register, plus room for the four-word byte queue.
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned RAND_BYTES      = 200;
  localparam int unsigned MAX_PRINTS      = 40;

  // Configuration register indexes.
  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_LOCK  = 2'd1;
  localparam logic [1:0] REG_TYPE  = 2'd2;
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_OK, ST_BUFEND, ST_BADTYPE, ST_LOCKED, ST_BADTHRESH
  } status_e;

  typedef enum logic [3:0] {
    PH_START, PH_ASSET, PH_TYPE, PH_AMOUNT, PH_LOCK, PH_THRESH, PH_NADDR, PH_ADDR
  } parse_phase_e;

  // Fault planted in the last record of a built transaction.
  typedef enum logic [1:0] {
    FLT_NONE, FLT_TYPE, FLT_LOCK, FLT_THRESH
  } fault_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] sum;
    logic [31:0] total;
  } status_word_t;

  // One directed transaction. Directed records carry an all-ones amount, zero threshold and
  // zero locktime unless a fault says otherwise, so the typed results read off directly.
  typedef struct packed {
    logic [2:0]  wmask;     // bit 0 count, bit 1 locktime check, bit 2 type id
    logic [15:0] count;
    logic        lock_on;
    logic [31:0] type_id;
    logic [1:0]  recs;      // records actually built
    fault_e      fault;
    logic [2:0]  naddr;     // addresses per record
    logic [7:0]  keep;      // cut the buffer to this many bytes, zero keeps all
    logic [2:0]  trail;     // extra random bytes after the records
    logic        typed;     // result below is checked as well as predicted
    status_e     e_status;
    logic [63:0] e_sum;
    logic [31:0] e_total;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [16] = '{
    // zero records straight after reset: the first byte reports ok, the next is dropped
    '{3'b000, 16'd0, 1'b0, 32'd0, 2'd0, FLT_NONE, 3'd0, 8'd0, 3'd2,
      1'b1, ST_OK, 64'd0, 32'd0},
    // reset type id still in force
    '{3'b001, 16'd1, 1'b0, 32'd0, 2'd1, FLT_NONE, 3'd1, 8'd0, 3'd0,
      1'b1, ST_OK, ALL_ONES, 32'd1},
    // one-byte buffer
    '{3'b111, 16'd1, 1'b0, 32'd0, 2'd1, FLT_NONE, 3'd0, 8'd1, 3'd0,
      1'b1, ST_BUFEND, 64'd0, 32'd0},
    // zero locktime passes with checking on, type id zero
    '{3'b111, 16'd1, 1'b1, 32'd0, 2'd1, FLT_NONE, 3'd0, 8'd0, 3'd0,
      1'b1, ST_OK, ALL_ONES, 32'd0},
    '{3'b111, 16'd1, 1'b1, 32'hFFFF_FFFF, 2'd1, FLT_TYPE, 3'd0, 8'd0, 3'd0,
      1'b1, ST_BADTYPE, 64'd0, 32'd0},
    // bad type on the final byte wins over buffer end
    '{3'b111, 16'd1, 1'b1, 32'hFFFF_FFFF, 2'd1, FLT_TYPE, 3'd0, 8'd36, 3'd0,
      1'b1, ST_BADTYPE, 64'd0, 32'd0},
    '{3'b111, 16'd1, 1'b1, 32'hFFFF_FFFF, 2'd1, FLT_LOCK, 3'd0, 8'd0, 3'd0,
      1'b1, ST_LOCKED, ALL_ONES, 32'd0},
    // nonzero locktime with checking off
    '{3'b111, 16'd1, 1'b0, 32'd7, 2'd1, FLT_LOCK, 3'd0, 8'd0, 3'd0,
      1'b1, ST_OK, ALL_ONES, 32'd0},
    '{3'b111, 16'd1, 1'b0, 32'd7, 2'd1, FLT_THRESH, 3'd0, 8'd0, 3'd0,
      1'b1, ST_BADTHRESH, ALL_ONES, 32'd0},
    // amount sum wraps
    '{3'b111, 16'd2, 1'b0, 32'd7, 2'd2, FLT_NONE, 3'd0, 8'd0, 3'd0,
      1'b1, ST_OK, 64'hFFFF_FFFF_FFFF_FFFE, 32'd0},
    // buffer ends inside the address list
    '{3'b111, 16'd1, 1'b0, 32'd7, 2'd1, FLT_NONE, 3'd2, 8'd80, 3'd0,
      1'b1, ST_BUFEND, ALL_ONES, 32'd1},
    // buffer ends between records
    '{3'b111, 16'd2, 1'b0, 32'd7, 2'd1, FLT_NONE, 3'd3, 8'd0, 3'd0,
      1'b1, ST_BUFEND, ALL_ONES, 32'd3},
    // bytes after a complete parse are dropped
    '{3'b111, 16'd1, 1'b0, 32'd7, 2'd1, FLT_NONE, 3'd1, 8'd0, 3'd5,
      1'b1, ST_OK, ALL_ONES, 32'd1},
    '{3'b111, 16'hFFFF, 1'b1, 32'd7, 2'd1, FLT_NONE, 3'd0, 8'd0, 3'd0,
      1'b1, ST_BUFEND, ALL_ONES, 32'd0},
    '{3'b111, 16'd3, 1'b1, 32'h1234_5678, 2'd3, FLT_NONE, 3'd1, 8'd0, 3'd0,
      1'b0, ST_OK, 64'd0, 32'd0},
    // threshold above a nonzero address count
    '{3'b111, 16'd1, 1'b0, 32'hA5A5_A5A5, 2'd1, FLT_THRESH, 3'd2, 8'd0, 3'd0,
      1'b0, ST_OK, 64'd0, 32'd0}
  };

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte     = 8'd0;
  logic        last_byte     = 1'b0;
  logic        out_valid;
  logic        out_rdy       = 1'b0;
  logic [2:0]  status;
  logic [63:0] amount_sum;
  logic [31:0] address_total;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index     = 2'd0;
  logic [31:0] cfg_data      = 32'd0;

  // Predictor copy of the registers.
  logic [15:0] pr_count;
  logic        pr_lock;
  logic [31:0] pr_type;

  // Predictor copy of the transaction state.
  parse_phase_e ph;
  int unsigned  fld_cnt;
  logic [63:0]  fld_acc;
  logic [31:0]  thresh;
  logic [31:0]  addr_left;
  logic [15:0]  rec_left;
  logic [63:0]  amt_sum;
  logic [31:0]  addr_tot;
  bit           reported;

  status_word_t pending_status [$];
  status_word_t last_seen;
  logic [7:0]   txn_bytes [$];

  int unsigned errors      = 0;
  int unsigned status_seen = 0;
  int unsigned bytes_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  logic [31:0] stall_pat   = '1;
  logic [4:0]  stall_pos   = '0;

  transfer_output_record_parser #(
    .ADDRESS_BYTES (ADDRESS_BYTES),
    .ASSET_ID_BYTES(ASSET_ID_BYTES)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_rdy),
    .status_o       (status),
    .amount_sum_o   (amount_sum),
    .address_total_o(address_total),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------------

  function automatic void clear_parse();
    ph        = PH_START;
    fld_cnt   = 0;
    fld_acc   = '0;
    thresh    = '0;
    addr_left = '0;
    rec_left  = '0;
    amt_sum   = '0;
    addr_tot  = '0;
    reported  = 1'b0;
  endfunction

  // Count off one record; report ok once the last one is done, else start the next.
  function automatic bit close_record();
    rec_left = rec_left - 16'd1;
    if (rec_left == 16'd0) return 1'b1;
    ph = PH_ASSET;
    return 1'b0;
  endfunction

  // Advance the parse by one accepted byte; return 1 when it decides a status word.
  function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                    output status_word_t word);
    bit          have;
    status_e     code;
    int unsigned span;
    logic [63:0] v;
    have = 1'b0;
    code = ST_OK;
    word = '0;
    if (!reported) begin
      // Latch the record count at the first byte of a transaction.
      if (ph == PH_START) begin
        rec_left = pr_count;
        ph       = PH_ASSET;
        fld_cnt  = 0;
        fld_acc  = '0;
        if (rec_left == 16'd0) have = 1'b1;
      end
      if (!have) begin
        case (ph)
          PH_ASSET:                     span = ASSET_ID_BYTES;
          PH_TYPE, PH_THRESH, PH_NADDR: span = 4;
          PH_AMOUNT, PH_LOCK:           span = 8;
          default:                      span = ADDRESS_BYTES;
        endcase
        fld_acc = {fld_acc[55:0], b};
        if (fld_cnt + 1 < span) begin
          fld_cnt = fld_cnt + 1;
        end else begin
          v       = fld_acc;
          fld_cnt = 0;
          fld_acc = '0;
          case (ph)
            PH_ASSET: ph = PH_TYPE;
            PH_TYPE: begin
              if (v[31:0] != pr_type) begin
                have = 1'b1;
                code = ST_BADTYPE;
              end else begin
                ph = PH_AMOUNT;
              end
            end
            PH_AMOUNT: begin
              amt_sum = amt_sum + v;
              ph      = PH_LOCK;
            end
            PH_LOCK: begin
              if (pr_lock && v != 64'd0) begin
                have = 1'b1;
                code = ST_LOCKED;
              end else begin
                ph = PH_THRESH;
              end
            end
            PH_THRESH: begin
              thresh = v[31:0];
              ph     = PH_NADDR;
            end
            PH_NADDR: begin
              addr_left = v[31:0];
              if (thresh > addr_left) begin
                have = 1'b1;
                code = ST_BADTHRESH;
              end else if (addr_left == 32'd0) begin
                have = close_record();
              end else begin
                ph = PH_ADDR;
              end
            end
            default: begin
              // Saturate the address total.
              if (addr_tot != '1) addr_tot = addr_tot + 32'd1;
              addr_left = addr_left - 32'd1;
              if (addr_left == 32'd0) have = close_record();
            end
          endcase
        end
      end
      if (!have && fin) begin
        have = 1'b1;
        code = ST_BUFEND;
      end
      if (have) begin
        word.status = code;
        word.sum    = amt_sum;
        word.total  = addr_tot;
        reported    = 1'b1;
      end
    end
    if (fin) clear_parse();
    return have;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------------

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (errors < MAX_PRINTS) $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  task automatic check_word(input string tag, input status_word_t got, input status_word_t want);
    if (got.status != want.status) begin
      report({tag, "status"}, 64'(got.status), 64'(want.status));
    end
    if (got.sum != want.sum) report({tag, "amount sum"}, got.sum, want.sum);
    if (got.total != want.total) begin
      report({tag, "address total"}, 64'(got.total), 64'(want.total));
    end
  endtask

  // Sample every channel at the clock edge: compare status words, predict from accepted bytes,
  // mirror register writes.
  always @(posedge clk) begin
    status_word_t got;
    status_word_t want;
    status_word_t pred;
    if (rst_n) begin
      if (out_valid && out_rdy) begin
        got.status  = status;
        got.sum     = amount_sum;
        got.total   = address_total;
        last_seen   = got;
        status_seen++;
        if (pending_status.size() == 0) begin
          report("status word with nothing pending", 64'(got.status), 64'd0);
        end else begin
          want = pending_status.pop_front();
          check_word("", got, want);
        end
      end
      if (in_valid && in_ready) begin
        if (parse_byte(data_byte, last_byte, pred)) pending_status.push_back(pred);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COUNT: pr_count = cfg_data[15:0];
          REG_LOCK:  pr_lock  = cfg_data[0];
          REG_TYPE:  pr_type  = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Receiver: stall on a 32-bit pattern, refreshed in one of four moods (never, random,
  // mostly stalled, rarely stalled).
  always @(posedge clk) begin
    if (stall_pos == 5'd0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat <= '1;
        1:       stall_pat <= $urandom;
        2:       stall_pat <= $urandom & $urandom;
        default: stall_pat <= $urandom | $urandom;
      endcase
    end
    out_rdy   <= stall_pat[stall_pos];
    stall_pos <= stall_pos + 5'd1;
  end

  // Watchdog: end the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_rdy) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------------

  task automatic push_be(input logic [63:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) txn_bytes.push_back(v[8*i +: 8]);
  endtask

  // Build one transaction buffer. With rnd set, draw the record contents; otherwise use the
  // directed contents. A negative keep cuts the buffer at a random point.
  task automatic build_txn(input int recs, input fault_e fault, input int naddr, input bit rnd,
                           input int keep, input int trail, input logic [31:0] tid);
    logic [31:0] n;
    logic [31:0] thr;
    logic [31:0] typ;
    logic [63:0] amt;
    logic [63:0] lock;
    fault_e      f;
    int unsigned shown;
    txn_bytes.delete();
    for (int k = 0; k < recs; k++) begin
      f = (k == recs - 1) ? fault : FLT_NONE;
      repeat (ASSET_ID_BYTES) txn_bytes.push_back(8'($urandom));
      if (rnd) begin
        n   = ($urandom_range(0, 15) < 13 || f == FLT_THRESH) ? $urandom_range(0, 3) : $urandom;
        thr = $urandom_range(0, n);
        case ($urandom_range(0, 3))
          0:       amt = ALL_ONES;
          1:       amt = '0;
          default: amt = {$urandom, $urandom};
        endcase
        lock = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom | 32'd1} : 64'd0;
      end else begin
        n    = naddr;
        thr  = '0;
        amt  = ALL_ONES;
        lock = '0;
      end
      typ = tid;
      if (f == FLT_TYPE)   typ  = rnd ? tid ^ ($urandom | 32'd1) : ~tid;
      if (f == FLT_LOCK)   lock = rnd ? {$urandom, $urandom | 32'd1} : 64'd1;
      if (f == FLT_THRESH) thr  = n + 32'd1;
      push_be(64'(typ), 4);
      push_be(amt, 8);
      push_be(lock, 8);
      push_be(64'(thr), 4);
      push_be(64'(n), 4);
      // Hold a huge address list to a few entries; the buffer then ends inside it.
      shown = (n > 4) ? 4 : n;
      repeat (shown * ADDRESS_BYTES) txn_bytes.push_back(8'($urandom));
      if (n > 4) break;
    end
    if (keep < 0 && txn_bytes.size() > 0) keep = $urandom_range(1, txn_bytes.size());
    if (keep > 0) begin
      while (txn_bytes.size() > keep) void'(txn_bytes.pop_back());
    end
    repeat (trail) txn_bytes.push_back(8'($urandom));
    if (txn_bytes.size() == 0) txn_bytes.push_back(8'($urandom));
  endtask

  // Send the built buffer in bursts; hold valid and the word until taken.
  task automatic send_txn();
    int unsigned gap;
    for (int i = 0; i < txn_bytes.size(); i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = 64;
          gap        = 0;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap        = $urandom_range(0, 5);
        end
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_valid  <= 1'b1;
      data_byte <= txn_bytes[i];
      last_byte <= (i == txn_bytes.size() - 1);
      do @(posedge clk); while (!in_ready);
      burst_left--;
      bytes_sent++;
    end
  endtask

  // Drop valid, wait for every pending status word, then let dropped bytes clear the queue.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin
    dir_row_t     row;
    status_word_t typed_word;
    logic [31:0]  want_type;
    logic [15:0]  count;
    logic         lock_on;
    logic [31:0]  tid;
    int           recs;
    int unsigned  sent_base;

    pr_count = '0;
    pr_lock  = 1'b0;
    pr_type  = 32'd7;
    clear_parse();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed transactions.
    for (int r = 0; r < $size(DIR_ROWS); r++) begin
      row       = DIR_ROWS[r];
      want_type = row.wmask[2] ? row.type_id : pr_type;
      if (row.wmask[0]) write_reg(REG_COUNT, {16'd0, row.count});
      if (row.wmask[1]) write_reg(REG_LOCK, {31'd0, row.lock_on});
      if (row.wmask[2]) write_reg(REG_TYPE, row.type_id);
      if (row.wmask != 3'b000) cfg_valid <= 1'b0;
      build_txn(int'(row.recs), row.fault, int'(row.naddr), 1'b0, int'(row.keep),
                int'(row.trail), want_type);
      send_txn();
      drain();
      if (row.typed) begin
        typed_word.status = row.e_status;
        typed_word.sum    = row.e_sum;
        typed_word.total  = row.e_total;
        check_word($sformatf("row %0d ", r), last_seen, typed_word);
      end
    end

    // Random phases: a fresh register setting, then a handful of transactions.
    sent_base = bytes_sent;
    while (bytes_sent - sent_base < RAND_BYTES) begin
      case ($urandom_range(0, 7))
        0:       count = 16'd0;
        1:       count = 16'hFFFF;
        2:       count = 16'($urandom);
        default: count = 16'($urandom_range(1, 3));
      endcase
      lock_on = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0:       tid = 32'd0;
        1:       tid = 32'hFFFF_FFFF;
        2:       tid = 32'd7;
        default: tid = $urandom;
      endcase
      // Fill the unused upper bits with noise; only the low bits may take effect.
      write_reg(REG_COUNT, {16'($urandom), count});
      write_reg(REG_LOCK, {31'($urandom), lock_on});
      write_reg(REG_TYPE, tid);
      if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE, $urandom);
      cfg_valid <= 1'b0;

      repeat ($urandom_range(3, 8)) begin
        if (bytes_sent - sent_base >= RAND_BYTES) break;
        recs = (count <= 16'd3) ? int'(count) : $urandom_range(0, 2);
        case ($urandom_range(0, 9))
          6:       build_txn(recs, fault_e'($urandom_range(1, 3)), 0, 1'b1, 0, 0, tid);
          7:       build_txn(recs, FLT_NONE, 0, 1'b1, -1, 0, tid);
          8:       build_txn(0, FLT_NONE, 0, 1'b1, 0, $urandom_range(1, 40), tid);
          default: build_txn(recs, FLT_NONE, 0, 1'b1, 0, $urandom_range(0, 3), tid);
        endcase
        send_txn();
      end
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> transfer_output_record_parser.f
sv/torp_pkg.sv
sv/torp_front.sv
sv/torp_queue.sv
sv/torp_back.sv
sv/transfer_output_record_parser.sv
bench/transfer_output_record_parser_test.sv
